// ===== design/integer_text_formatter_macros.svh =====
// Assertion macros for the integer text formatter.
// Each macro takes a label, clock, reset, antecedent, consequent and message.
`ifndef INTEGER_TEXT_FORMATTER_MACROS_SVH
`define INTEGER_TEXT_FORMATTER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define ITF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication
`define ITF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ITF_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ITF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== design/itf_pkg.sv =====
`timescale 1ns / 1ps
package itf_pkg;

   // sizing
   localparam int DEFAULT_MAX_DIGITS = 48;
   localparam int BUFFER_CHARS       = 64;
   localparam int VALUE_W            = 64;
   localparam int DIGIT_W            = 4;
   localparam int CHAR_W             = 8;
   localparam int OP_W               = 3;
   localparam int FLAGS_W            = 6;
   localparam int PREC_W             = 6;
   localparam int FIELD_W            = $clog2(BUFFER_CHARS + 1);

   // request tdata layout, lowest bit first
   localparam int REQ_FLAGS_LSB = VALUE_W;
   localparam int REQ_WIDTH_LSB = REQ_FLAGS_LSB + FLAGS_W;
   localparam int REQ_PREC_LSB  = REQ_WIDTH_LSB + FIELD_W;
   localparam int REQ_USED_W    = REQ_PREC_LSB + PREC_W;
   localparam int REQ_TDATA_W   = ((REQ_USED_W + 7) / 8) * 8;

   // operation codes
   localparam logic [OP_W-1:0] OP_SDEC       = 3'd0;
   localparam logic [OP_W-1:0] OP_UDEC       = 3'd1;
   localparam logic [OP_W-1:0] OP_OCT        = 3'd2;
   localparam logic [OP_W-1:0] OP_HEX_LOWER  = 3'd3;
   localparam logic [OP_W-1:0] OP_HEX_UPPER  = 3'd4;

   // flag bit positions
   localparam int FLAG_LEFT_BIT  = 2;
   localparam int FLAG_SPACE_BIT = 3;
   localparam int FLAG_PLUS_BIT  = 4;
   localparam int FLAG_GROUP_BIT = 5;

   // characters
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_COMMA   = 8'h2C;
   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_HEX = 2'd2
   } itf_radix_type;

   // one item's formatting job, captured at the request transfer
   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic               left;
      logic               group;
      logic [FIELD_W-1:0] min_width;
      logic [PREC_W-1:0]  precision;
      logic               has_sign;
      logic [CHAR_W-1:0]  sign_char;
   } itf_job_type;

   typedef struct packed {
      logic load;
      logic shift;
   } itf_conv_ctrl_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DIGIT_W-1:0] top_digit;
   } itf_conv_status_type;

   // ASCII for one digit
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                    input logic upper);
      logic [CHAR_W-1:0] d_ext;
      d_ext = CHAR_W'(d);
      if (d < 4'd10)
         return CHAR_ZERO + d_ext;
      else if (upper)
         return CHAR_UPPER_A + d_ext - 8'd10;
      else
         return CHAR_LOWER_A + d_ext - 8'd10;
   endfunction

   // x / 3 by reciprocal (43 / 128), exact for x below 128
   function automatic logic [FIELD_W-2:0] div3(input logic [FIELD_W-1:0] x);
      logic [2*FIELD_W-2:0] p;
      p = (2*FIELD_W-1)'(x) * (2*FIELD_W-1)'(43);
      return p[2*FIELD_W-2:FIELD_W];
   endfunction

endpackage

// ===== design/itf_convert.sv =====
`timescale 1ns / 1ps
module itf_convert import itf_pkg::*; #(
   parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS,
   localparam int CNT_W = $clog2(MAX_DIGITS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  itf_conv_ctrl_type   ctrl,
   input  itf_radix_type       radix,
   input  logic [VALUE_W-1:0]  magnitude,
   output itf_conv_status_type status,
   output logic [CNT_W-1:0]    sig
);

   localparam int BITCNT_W = $clog2(VALUE_W);

   logic [VALUE_W-1:0]  shift_ff, shift_in;
   logic [BITCNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic                running_ff, running_in;
   logic                done_ff, done_in;
   itf_radix_type       radix_ff, radix_in;
   logic [DIGIT_W-1:0]  digit_ff [MAX_DIGITS];
   logic [DIGIT_W-1:0]  digit_in [MAX_DIGITS];
   logic [MAX_DIGITS-1:0] mask_ff, mask_in;
   logic [MAX_DIGITS-1:0] carry;
   logic [MAX_DIGITS-1:0] grow_vec;
   logic [CNT_W-1:0]    sig_ff, sig_in;
   logic [DIGIT_W:0]    radix_val;
   logic [DIGIT_W-1:0]  half_val;

   // one digit cell: doubles and adds the bit from below, folds at the radix
   function automatic logic [DIGIT_W-1:0] cell_next(input logic [DIGIT_W-1:0] d,
                                                    input logic cin,
                                                    input logic cout,
                                                    input logic [DIGIT_W:0] rad);
      logic [DIGIT_W:0] dbl;
      dbl = {d, cin};
      if (cout)
         dbl = dbl - rad;
      return dbl[DIGIT_W-1:0];
   endfunction

   // radix of the current job
   always_comb begin
      case (radix_ff)
         RADIX_DEC: radix_val = 5'd10;
         RADIX_OCT: radix_val = 5'd8;
         default:   radix_val = 5'd16;
      endcase
      half_val = radix_val[DIGIT_W:1];
   end

   // carries depend only on the stored digit; mask marks significant digits
   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++)
         carry[i] = (digit_ff[i] >= half_val);
      grow_vec[0] = ~mask_ff[0] & shift_ff[VALUE_W-1];
      for (int i = 1; i < MAX_DIGITS; i++)
         grow_vec[i] = ~mask_ff[i] & mask_ff[i-1] & carry[i-1];
   end

   // load, bit step or digit shift towards the top
   always_comb begin
      shift_in   = shift_ff;
      bit_cnt_in = bit_cnt_ff;
      running_in = running_ff;
      done_in    = done_ff;
      radix_in   = radix_ff;
      mask_in    = mask_ff;
      sig_in     = sig_ff;
      digit_in   = digit_ff;
      if (ctrl.load) begin
         shift_in   = magnitude;
         bit_cnt_in = '0;
         running_in = 1'b1;
         done_in    = 1'b0;
         radix_in   = radix;
         mask_in    = '0;
         sig_in     = '0;
         for (int i = 0; i < MAX_DIGITS; i++)
            digit_in[i] = '0;
      end else if (running_ff) begin
         shift_in   = {shift_ff[VALUE_W-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + 1'b1;
         if (&bit_cnt_ff) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
         digit_in[0] = cell_next(digit_ff[0], shift_ff[VALUE_W-1], carry[0], radix_val);
         for (int i = 1; i < MAX_DIGITS; i++)
            digit_in[i] = cell_next(digit_ff[i], carry[i-1], carry[i], radix_val);
         mask_in = mask_ff | grow_vec;
         sig_in  = sig_ff + CNT_W'(|grow_vec);
      end else if (ctrl.shift) begin
         digit_in[0] = '0;
         for (int i = 1; i < MAX_DIGITS; i++)
            digit_in[i] = digit_ff[i-1];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      bit_cnt_ff <= bit_cnt_in;
      radix_ff   <= radix_in;
      mask_ff    <= mask_in;
      sig_ff     <= sig_in;
      digit_ff   <= digit_in;
   end

   assign status.busy      = running_ff;
   assign status.done      = done_ff;
   assign status.top_digit = digit_ff[MAX_DIGITS-1];
   assign sig              = sig_ff;

endmodule

// ===== design/itf_emit.sv =====
`timescale 1ns / 1ps
module itf_emit import itf_pkg::*; #(
   parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS,
   localparam int CNT_W = $clog2(MAX_DIGITS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  itf_job_type         job,
   input  itf_conv_status_type conv_status,
   input  logic [CNT_W-1:0]    sig,
   output itf_conv_ctrl_type   conv_ctrl,
   output logic                idle,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CHAR_W-1:0]   rsp_char,
   output logic                rsp_last
);

   localparam logic [FIELD_W-1:0] MAX_DIGITS_F = FIELD_W'(MAX_DIGITS);
   localparam logic [FIELD_W-1:0] BUFFER_F     = FIELD_W'(BUFFER_CHARS);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_CONV  = 10'b00_0000_0010,
      ST_SETUP = 10'b00_0000_0100,
      ST_SIZE  = 10'b00_0000_1000,
      ST_ALIGN = 10'b00_0001_0000,
      ST_LPAD  = 10'b00_0010_0000,
      ST_SIGN  = 10'b00_0100_0000,
      ST_DIGIT = 10'b00_1000_0000,
      ST_COMMA = 10'b01_0000_0000,
      ST_RPAD  = 10'b10_0000_0000
   } itf_state_type;

   itf_state_type      state_ff, state_in;
   itf_job_type        job_ff, job_in;
   logic [CNT_W-1:0]   ndig_ff, ndig_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [1:0]         kmod_ff, kmod_in;
   logic [FIELD_W-1:0] pad_ff, pad_in;
   logic [CNT_W-1:0]   align_ff, align_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic               emit;
   logic [CHAR_W-1:0]  emit_char;
   logic               emit_last;

   logic [FIELD_W-1:0] sig_f, prec_c, nd_a, nd_full;
   logic [FIELD_W-1:0] nm1, q3, rem, commas, field, width_c;
   logic [FIELD_W-2:0] q;

   // digit count: significant digits, precision (capped) and at least one
   always_comb begin
      sig_f   = FIELD_W'(sig);
      prec_c  = (FIELD_W'(job_ff.precision) > MAX_DIGITS_F) ? MAX_DIGITS_F
                                                             : FIELD_W'(job_ff.precision);
      nd_a    = (sig_f > prec_c) ? sig_f : prec_c;
      nd_full = (nd_a == '0) ? FIELD_W'(1) : nd_a;
   end

   // field length, pad and position of the first comma
   always_comb begin
      nm1     = FIELD_W'(ndig_ff) - FIELD_W'(1);
      q       = div3(nm1);
      q3      = {q, 1'b0} + {1'b0, q};
      rem     = nm1 - q3;
      commas  = job_ff.group ? FIELD_W'(q) : '0;
      field   = FIELD_W'(ndig_ff) + commas + FIELD_W'(job_ff.has_sign);
      width_c = (job_ff.min_width > BUFFER_F) ? BUFFER_F : job_ff.min_width;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // sequencer
   always_comb begin
      state_in        = state_ff;
      job_in          = job_ff;
      ndig_in         = ndig_ff;
      k_in            = k_ff;
      kmod_in         = kmod_ff;
      pad_in          = pad_ff;
      align_in        = align_ff;
      emit            = 1'b0;
      emit_char       = CHAR_SPACE;
      emit_last       = 1'b0;
      conv_ctrl.load  = start;
      conv_ctrl.shift = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               job_in   = job;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv_status.done)
               state_in = ST_SETUP;
         end
         ST_SETUP: begin
            ndig_in  = CNT_W'(nd_full);
            k_in     = CNT_W'(nd_full - FIELD_W'(1));
            align_in = CNT_W'(MAX_DIGITS_F - nd_full);
            state_in = ST_SIZE;
         end
         ST_SIZE: begin
            kmod_in  = rem[1:0];
            pad_in   = (width_c > field) ? (width_c - field) : '0;
            state_in = ST_ALIGN;
         end
         ST_ALIGN: begin
            // bring the leading digit to the top cell
            if (align_ff == '0) begin
               state_in = ST_LPAD;
            end else begin
               conv_ctrl.shift = 1'b1;
               align_in        = align_ff - 1'b1;
            end
         end
         ST_LPAD: begin
            if (job_ff.left || pad_ff == '0) begin
               state_in = ST_SIGN;
            end else if (out_free) begin
               emit   = 1'b1;
               pad_in = pad_ff - 1'b1;
            end
         end
         ST_SIGN: begin
            if (!job_ff.has_sign) begin
               state_in = ST_DIGIT;
            end else if (out_free) begin
               emit      = 1'b1;
               emit_char = job_ff.sign_char;
               state_in  = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               emit            = 1'b1;
               emit_char       = digit_char(conv_status.top_digit,
                                            job_ff.operation == OP_HEX_UPPER);
               conv_ctrl.shift = 1'b1;
               if (k_ff == '0) begin
                  emit_last = !(job_ff.left && pad_ff != '0);
                  state_in  = emit_last ? ST_IDLE : ST_RPAD;
               end else begin
                  k_in    = k_ff - 1'b1;
                  kmod_in = (kmod_ff == 2'd0) ? 2'd2 : kmod_ff - 2'd1;
                  if (job_ff.group && kmod_ff == 2'd0)
                     state_in = ST_COMMA;
               end
            end
         end
         ST_COMMA: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = CHAR_COMMA;
               state_in  = ST_DIGIT;
            end
         end
         ST_RPAD: begin
            if (out_free) begin
               emit   = 1'b1;
               pad_in = pad_ff - 1'b1;
               if (pad_ff == FIELD_W'(1)) begin
                  emit_last = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_last_in  = emit_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      ndig_ff     <= ndig_in;
      k_ff        <= k_in;
      kmod_ff     <= kmod_in;
      pad_ff      <= pad_in;
      align_ff    <= align_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign idle      = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_char  = rsp_char_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ===== design/integer_text_formatter.sv =====
`timescale 1ns / 1ps
`include "integer_text_formatter_macros.svh"
// Integer text formatter: turns one 64-bit integer into printf-style ASCII text.
// Request channel (req_*): one transfer per number; tuser holds the conversion
// (signed/unsigned decimal, octal, lower/upper hex), tdata the value and format.
// Response channel (rsp_*): one transfer per character, leftmost first, tlast on
// the final character. Every number yields between 1 and 64 characters.
// The value is shifted into a row of radix digit cells one bit per cycle; the
// setup and size states follow, then the leading digit is shifted to the top
// cell, one shift for each unused digit position (MAX_DIGITS minus digits
// printed). The first character is registered after that alignment; the left
// pad and sign states pass without output where no left pad or no sign is due.
// Characters then leave at one per cycle while the receiver accepts them, with
// a pause as the left pad ends and another where no sign is due.
// A new request is taken only once the sequencer is back in idle, which is as
// soon as the last character of the previous number is registered.
// A stalled receiver holds the output register and the character-emitting states.
// Reset empties the output register and returns the sequencer to idle.
module integer_text_formatter import itf_pkg::*; #(
   parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // value[63:0], format_flags[69:64], min_width[76:70], precision[82:77], zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // operation[2:0]
   input  logic [OP_W-1:0]        req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // character[7:0]
   output logic [CHAR_W-1:0]      rsp_tdata,
   output logic                   rsp_tlast
);

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);

   logic                req_xfer;
   logic [VALUE_W-1:0]  value;
   logic [FLAGS_W-1:0]  flags;
   logic [OP_W-1:0]     op_n;
   logic                negative;
   logic [VALUE_W-1:0]  magnitude;
   itf_radix_type       radix;
   itf_job_type         job;
   itf_conv_ctrl_type   conv_ctrl;
   itf_conv_status_type conv_status;
   logic [CNT_W-1:0]    sig;
   logic                idle;

   assign req_tready = idle;
   assign req_xfer   = req_tvalid && req_tready;
   assign value      = req_tdata[VALUE_W-1:0];
   assign flags      = req_tdata[REQ_FLAGS_LSB +: FLAGS_W];

   // unused codes fall back to unsigned decimal
   always_comb begin
      case (req_tuser)
         OP_SDEC, OP_UDEC, OP_OCT, OP_HEX_LOWER, OP_HEX_UPPER: op_n = req_tuser;
         default: op_n = OP_UDEC;
      endcase
      case (op_n)
         OP_SDEC, OP_UDEC: radix = RADIX_DEC;
         OP_OCT:           radix = RADIX_OCT;
         default:          radix = RADIX_HEX;
      endcase
   end

   // sign and magnitude; the most negative value wraps to its own magnitude
   always_comb begin
      negative  = (op_n == OP_SDEC) && value[VALUE_W-1];
      magnitude = negative ? VALUE_W'(~value + 1'b1) : value;
      job.operation = op_n;
      job.left      = flags[FLAG_LEFT_BIT];
      job.group     = flags[FLAG_GROUP_BIT];
      job.min_width = req_tdata[REQ_WIDTH_LSB +: FIELD_W];
      job.precision = req_tdata[REQ_PREC_LSB +: PREC_W];
      job.has_sign  = 1'b0;
      job.sign_char = CHAR_SPACE;
      if (negative) begin
         job.has_sign  = 1'b1;
         job.sign_char = CHAR_MINUS;
      end else if (op_n == OP_SDEC && flags[FLAG_PLUS_BIT]) begin
         job.has_sign  = 1'b1;
         job.sign_char = CHAR_PLUS;
      end else if (op_n == OP_SDEC && flags[FLAG_SPACE_BIT]) begin
         job.has_sign  = 1'b1;
         job.sign_char = CHAR_SPACE;
      end
   end

   itf_convert #(.MAX_DIGITS(MAX_DIGITS)) u_convert (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (conv_ctrl),
      .radix     (radix),
      .magnitude (magnitude),
      .status    (conv_status),
      .sig       (sig)
   );

   itf_emit #(.MAX_DIGITS(MAX_DIGITS)) u_emit (
      .clock       (clock),
      .reset       (reset),
      .start       (req_xfer),
      .job         (job),
      .conv_status (conv_status),
      .sig         (sig),
      .conv_ctrl   (conv_ctrl),
      .idle        (idle),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_char    (rsp_tdata),
      .rsp_last    (rsp_tlast)
   );

   // checks
   `ITF_ASSERT_IMPL(a_req_when_free, clock, reset, req_tvalid && req_tready,
                    !conv_status.busy, "request taken while conversion running")
   `ITF_ASSERT_NEXT(a_conv_starts, clock, reset, req_tvalid && req_tready,
                    conv_status.busy, "conversion did not start after request")
   `ITF_ASSERT_IMPL(a_no_shift_busy, clock, reset, conv_ctrl.shift,
                    !conv_status.busy, "digit shift during conversion")
   `ITF_ASSERT_IMPL(a_done_after_run, clock, reset, $rose(conv_status.done),
                    $past(conv_status.busy), "conversion done without running")

endmodule
